FILE: design/tht_pkg.sv
// Shared types and constants of the timed hysteresis trigger.
package tht_pkg;

	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 16;
	localparam int TICK_W   = 16;
	localparam int TOTAL_W  = 32;
	localparam int CFG_W    = 32;
	localparam int REGIDX_W = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Register indexes of the configuration port
	localparam logic [REGIDX_W-1:0] REG_TRIGGER_LEVEL = 2'd0;
	localparam logic [REGIDX_W-1:0] REG_SUSTAIN_TICKS = 2'd1;
	localparam logic [REGIDX_W-1:0] REG_SILENCE_TICKS = 2'd2;

	typedef struct packed {
		logic [CHAN_W-1:0]          channel;
		logic signed [SAMPLE_W-1:0] sample;
		logic [TICK_W-1:0]          elapsed_ticks;
	} in_beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic              now_triggered;
		logic              fire_event;
	} out_beat_t;

	// Per-channel state word kept in the state memory
	typedef struct packed {
		logic               armed;
		logic [TOTAL_W-1:0] total;
	} chan_state_t;

	// Outcome of one update: whether the channel changed state, and to what
	typedef struct packed {
		logic hit;
		logic now_triggered;
	} upd_res_t;

endpackage

FILE: design/tht_state_mem.sv
// Per-channel state memory: one write port, one registered read port, valid bits.
module tht_state_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output tht_pkg::chan_state_t rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  tht_pkg::chan_state_t wr_data
);
	import tht_pkg::*;

	chan_state_t       mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	chan_state_t       rd_data_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Entries never written read as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

`ifndef SYNTHESIS
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (32'(rd_addr) < DEPTH))
		else $error("state memory read beyond depth");
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < DEPTH))
		else $error("state memory write beyond depth");
	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(wr_addr)])
		else $error("written entry not marked valid");
`endif

endmodule

FILE: design/tht_update.sv
// Channel state update: accumulate time, compare against threshold, flip state.
module tht_update (
	input  tht_pkg::chan_state_t              cur,
	input  logic signed [tht_pkg::SAMPLE_W-1:0] sample,
	input  logic [tht_pkg::TICK_W-1:0]        elapsed_ticks,
	input  logic signed [tht_pkg::SAMPLE_W-1:0] trigger_level,
	input  logic [tht_pkg::TOTAL_W-1:0]       sustain_ticks,
	input  logic [tht_pkg::TOTAL_W-1:0]       silence_ticks,
	output tht_pkg::chan_state_t              nxt,
	output tht_pkg::upd_res_t                 res
);
	import tht_pkg::*;

	logic               above;
	logic               counting;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sat;
	logic [TOTAL_W-1:0] thr;

	assign above    = sample >= trigger_level;
	// Idle channels count time above level, triggered ones time below
	assign counting = cur.armed ? !above : above;
	assign thr      = cur.armed ? silence_ticks : sustain_ticks;
	assign sum      = {1'b0, cur.total} + {{(TOTAL_W + 1 - TICK_W){1'b0}}, elapsed_ticks};
	assign sat      = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	always_comb begin
		nxt.armed         = cur.armed;
		nxt.total         = '0;
		res.hit           = 1'b0;
		res.now_triggered = !cur.armed;
		if (counting) begin
			if (sat > thr) begin
				nxt.armed = !cur.armed;
				res.hit   = 1'b1;
			end else begin
				nxt.total = sat;
			end
		end
	end

endmodule

FILE: design/tht_out_fifo.sv
// Four-entry result queue between the update stage and the output channel.
module tht_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tht_pkg::out_beat_t push_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tht_pkg::out_beat_t out_data,
	output logic [2:0]         count
);
	import tht_pkg::*;

	out_beat_t  buf_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != 3'd0;
	assign out_data  = buf_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'b0, push} - {2'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 3'd4) |-> !push || pop)
		else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

FILE: design/timed_hysteresis_trigger.sv
// Top level of the multi-channel timed hysteresis trigger.
//
//  port group   dir  handshake           payload
//  in_*         in   in_valid/in_ready   in_data   (channel, sample, elapsed_ticks)
//  out_*        out  out_valid/out_ready out_data  (out_channel, now_triggered, fire_event)
//  cfg_*        in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
// Takes one input beat per clock while in_ready is high. A beat reads its channel
// state from the state memory at acceptance, updates and writes it back in the
// next cycle, and, when the channel changes state, pushes its result into the
// output queue at that same edge; the result is offered from then on.
// Back-to-back beats on one channel are served by forwarding the write-back.
// Reset clears per-entry valid bits at once, so there is no clearing pass.
// The four-entry output queue absorbs stalls; in_ready drops once queued plus
// in-flight results reach three.
module timed_hysteresis_trigger #(
	parameter int CHANNELS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tht_pkg::in_beat_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tht_pkg::out_beat_t             out_data,
	input  logic                           cfg_we,
	input  logic [tht_pkg::REGIDX_W-1:0]   cfg_index,
	input  logic [tht_pkg::CFG_W-1:0]      cfg_wdata
);
	import tht_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Shared configuration registers
	logic signed [SAMPLE_W-1:0] level_q;
	logic [TOTAL_W-1:0]         sustain_q;
	logic [TOTAL_W-1:0]         silence_q;

	// Accept stage
	logic                        accept;
	logic                        in_range;
	logic [CHAN_W+IDX_W-1:0]     chan_ext;
	logic [IDX_W-1:0]            in_idx;
	logic [2:0]                  fifo_count;
	logic [2:0]                  occupancy;

	// Update stage
	logic                        valid_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [CHAN_W-1:0]           chan_s1;
	logic signed [SAMPLE_W-1:0]  sample_s1;
	logic [TICK_W-1:0]           dt_s1;
	logic                        byp_s1;
	chan_state_t                 byp_data_s1;

	chan_state_t                 rd_state;
	chan_state_t                 cur_state;
	chan_state_t                 nxt_state;
	upd_res_t                    upd_res;
	out_beat_t                   res_beat;

	// Configuration writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			sustain_q <= '0;
			silence_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIGGER_LEVEL: level_q   <= cfg_wdata[SAMPLE_W-1:0];
				REG_SUSTAIN_TICKS: sustain_q <= cfg_wdata[TOTAL_W-1:0];
				REG_SILENCE_TICKS: silence_q <= cfg_wdata[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold off input once the queue could not take every in-flight result
	assign occupancy = fifo_count + {2'b0, valid_s1};
	assign in_ready  = occupancy < 3'd3;
	assign accept    = in_valid && in_ready;

	// Channels beyond the configured count are taken and dropped
	assign in_range = 32'(in_data.channel) < CHANNELS;
	assign chan_ext = (CHAN_W + IDX_W)'(in_data.channel);
	assign in_idx   = chan_ext[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept && in_range;
			// Forward when the beat in flight writes the entry being read now
			byp_s1   <= valid_s1 && (idx_s1 == in_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1    <= in_idx;
			chan_s1   <= in_data.channel;
			sample_s1 <= in_data.sample;
			dt_s1     <= in_data.elapsed_ticks;
		end
		byp_data_s1 <= nxt_state;
	end

	tht_state_mem #(
		.DEPTH  (CHANNELS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (in_idx),
		.rd_data (rd_state),
		.wr_en   (valid_s1),
		.wr_addr (idx_s1),
		.wr_data (nxt_state)
	);

	assign cur_state = byp_s1 ? byp_data_s1 : rd_state;

	tht_update u_update (
		.cur           (cur_state),
		.sample        (sample_s1),
		.elapsed_ticks (dt_s1),
		.trigger_level (level_q),
		.sustain_ticks (sustain_q),
		.silence_ticks (silence_q),
		.nxt           (nxt_state),
		.res           (upd_res)
	);

	// Fire only on becoming triggered, so the event mirrors the new state
	assign res_beat.out_channel   = chan_s1;
	assign res_beat.now_triggered = upd_res.now_triggered;
	assign res_beat.fire_event    = upd_res.now_triggered;

	tht_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1 && upd_res.hit),
		.push_data (res_beat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.count     (fifo_count)
	);

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= 3'd4)
		else $error("more results in flight than the queue holds");
	a_bypass_same_chan: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && byp_s1) |-> ($past(valid_s1) && idx_s1 == $past(idx_s1)))
		else $error("forwarding taken for a different channel");
	a_fire_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.fire_event == out_data.now_triggered))
		else $error("fire event disagrees with new state");
	a_stage_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(accept))
		else $error("update stage active without an accepted beat");
`endif

endmodule

FILE: tb/timed_hysteresis_trigger_tb.sv
// Self-checking testbench for the multi-channel timed hysteresis trigger.
module timed_hysteresis_trigger_tb;
	import tht_pkg::*;

	localparam int CHANNELS = 16;
	// Index 3 maps to no register; a write there must leave every setting alone
	localparam logic [REGIDX_W-1:0] REG_UNMAPPED = 2'd3;
	// A beat's result passes the update stage before the output queue; leave margin
	localparam int SETTLE_CYCLES = 4;
	localparam int CHUNK_ITEMS = 130;
	localparam int LONG_ITEMS = 20;
	localparam logic [TOTAL_W-1:0] LONG_TOTAL = TOTAL_W'(LONG_ITEMS * 65535);

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;
	logic cfg_we;
	logic [REGIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	// Predicted register file
	logic signed [SAMPLE_W-1:0] level_cfg;
	logic [TOTAL_W-1:0] sustain_cfg;
	logic [TOTAL_W-1:0] silence_cfg;

	// Predicted per-channel state
	logic chan_armed [CHANNELS];
	logic [TOTAL_W-1:0] chan_total [CHANNELS];

	// Per-channel drift of the random samples: above or below the level
	bit heading_up [CHANNELS];

	out_beat_t expected_changes [$];
	int mismatch_count = 0;
	int send_idle_pct;
	int recv_idle_pct;

	timed_hysteresis_trigger #(.CHANNELS(CHANNELS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Receiver: stall at random, at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Compare every result beat against the oldest predicted state change
	always @(posedge clk) begin : check_results
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_changes.size() == 0) begin
				report_mismatch($sformatf("unexpected beat ch=%0d trig=%0b fire=%0b",
					out_data.out_channel, out_data.now_triggered, out_data.fire_event));
			end else begin
				want = expected_changes.pop_front();
				if (out_data.out_channel !== want.out_channel)
					report_mismatch($sformatf("out_channel %0d, want %0d",
						out_data.out_channel, want.out_channel));
				if (out_data.now_triggered !== want.now_triggered)
					report_mismatch($sformatf("ch %0d now_triggered %0b, want %0b",
						want.out_channel, out_data.now_triggered, want.now_triggered));
				if (out_data.fire_event !== want.fire_event)
					report_mismatch($sformatf("ch %0d fire_event %0b, want %0b",
						want.out_channel, out_data.fire_event, want.fire_event));
			end
		end
	end

	// Advance the predicted channel state by one accepted sample
	task automatic apply_sample(input in_beat_t b);
		logic [TOTAL_W:0] sum;
		logic above;
		int ch;
		out_beat_t change;
		ch = b.channel;
		if (ch >= CHANNELS)
			return;
		above = ($signed(b.sample) >= $signed(level_cfg));
		// Idle and above, or triggered and below: accumulate toward a change
		if (chan_armed[ch] != above) begin
			sum = {1'b0, chan_total[ch]} + b.elapsed_ticks;
			chan_total[ch] = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
			if (chan_total[ch] > (above ? sustain_cfg : silence_cfg)) begin
				chan_armed[ch] = above;
				chan_total[ch] = '0;
				change.out_channel = b.channel;
				change.now_triggered = above;
				change.fire_event = above;
				expected_changes.push_back(change);
			end
		end else begin
			// Opposite condition: drop the running total
			chan_total[ch] = '0;
		end
	endtask

	// Offer one beat, idling each cycle at the phase's rate; hold it until accepted
	task automatic send_sample(input logic [CHAN_W-1:0] ch, input int value, input int ticks);
		in_beat_t b;
		b.channel = ch;
		b.sample = value[SAMPLE_W-1:0];
		b.elapsed_ticks = ticks[TICK_W-1:0];
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		apply_sample(b);
	endtask

	// Drop valid, drain every expected result, then let in-flight beats retire
	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		while (expected_changes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TRIGGER_LEVEL: level_cfg = value[SAMPLE_W-1:0];
			REG_SUSTAIN_TICKS: sustain_cfg = value[TOTAL_W-1:0];
			REG_SILENCE_TICKS: silence_cfg = value[TOTAL_W-1:0];
			default: ;
		endcase
	endtask

	// Reprogram all registers once the block is idle, plus a stray unmapped write
	task automatic program_all(input int lvl, input logic [TOTAL_W-1:0] sustain,
			input logic [TOTAL_W-1:0] silence);
		wait_for_quiet();
		write_reg(REG_UNMAPPED, $urandom);
		write_reg(REG_TRIGGER_LEVEL, CFG_W'(lvl));
		write_reg(REG_SUSTAIN_TICKS, sustain);
		write_reg(REG_SILENCE_TICKS, silence);
	endtask

	function automatic logic [TOTAL_W-1:0] pick_threshold();
		case ($urandom_range(9))
			0: return '0;
			1: return TOTAL_MAX;
			2: return $urandom;
			default: return $urandom_range(1500);
		endcase
	endfunction

	// Reset settings, field extremes, zero ticks and both level extremes
	task automatic test_directed_extremes();
		// All registers at zero: any non-negative sample is above
		send_sample(4'd0, 0, 0);          // zero ticks: total stays at zero
		send_sample(4'd0, 0, 1);          // exceeds zero sustain: trigger
		send_sample(4'd0, -1, 0);         // below, but total not past zero
		send_sample(4'd0, -1, 65535);     // release
		program_all(32767, 100, 65535);
		send_sample(4'd15, 32767, 100);   // equal to sustain, not past it
		send_sample(4'd15, 32767, 1);     // trigger
		send_sample(4'd15, 32766, 65535); // equal to silence
		send_sample(4'd15, 32767, 5);     // back above: clear the total
		send_sample(4'd15, -32768, 65535);
		send_sample(4'd15, -32768, 1);    // release
		send_sample(4'd8, 16'h5555, 16'hAAAA);
		send_sample(4'd9, 16'hAAAA, 16'h5555);
		// Lowest level: nothing is below, channels can only trigger
		program_all(-32768, 100, 0);
		send_sample(4'd7, -32768, 65535);
		send_sample(4'd7, 32767, 65535);
		send_sample(4'd6, 12345, 101);
		send_sample(4'd5, -12345, 50);
		send_sample(4'd5, -12345, 51);
	endtask

	// Random runs above and below the level, reconfigured in chunks
	task automatic test_random_traffic(input int n_items);
		int lvl;
		int smp;
		int dt;
		int span;
		logic [CHAN_W-1:0] ch;
		for (int i = 0; i < n_items; i++) begin
			if (i % CHUNK_ITEMS == 0) begin
				case ($urandom_range(5))
					0: lvl = -32768;
					1: lvl = 32767;
					2: lvl = int'($urandom_range(65535)) - 32768;
					default: lvl = int'($urandom_range(2000)) - 1000;
				endcase
				program_all(lvl, pick_threshold(), pick_threshold());
			end
			// Keep most beats on a few channels so runs build up
			ch = ($urandom_range(9) < 7) ? CHAN_W'($urandom_range(3)) : CHAN_W'($urandom);
			if ($urandom_range(11) == 0)
				heading_up[ch] = ~heading_up[ch];
			lvl = level_cfg;
			if ($urandom_range(9) == 0) begin
				smp = int'($urandom_range(65535)) - 32768;
			end else if (heading_up[ch] || lvl == -32768) begin
				span = 32767 - lvl;
				if (span > 16 && $urandom_range(1))
					span = 16;
				smp = lvl + int'($urandom_range(span));
			end else begin
				span = lvl + 32767;
				if (span > 16 && $urandom_range(1))
					span = 16;
				smp = lvl - 1 - int'($urandom_range(span));
			end
			case ($urandom_range(9))
				0: dt = 0;
				1: dt = 65535;
				2: dt = $urandom_range(65535);
				default: dt = $urandom_range(300);
			endcase
			send_sample(ch, smp, dt);
		end
	endtask

	// Build large totals on one idle and one triggered channel against top thresholds
	task automatic test_long_accumulation();
		// Leave channel 10 triggered and channel 5 idle, both with a clear total
		program_all(0, 0, 0);
		send_sample(4'd10, 100, 1);
		send_sample(4'd5, -1000, 1);
		program_all(0, TOTAL_MAX, TOTAL_MAX);
		// Neither threshold can be exceeded while the totals grow
		for (int i = 0; i < LONG_ITEMS; i++) begin
			send_sample(4'd5, 1000, 65535);
			send_sample(4'd10, -1000, 65535);
		end
		// Thresholds equal to the totals: hold
		program_all(0, LONG_TOTAL, LONG_TOTAL);
		send_sample(4'd5, 1000, 0);
		send_sample(4'd10, -1000, 0);
		// One below the totals: both channels flip
		program_all(0, LONG_TOTAL - 1, LONG_TOTAL - 1);
		send_sample(4'd5, 1000, 0);
		send_sample(4'd10, -1000, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TRIGGER_LEVEL;
		cfg_wdata = '0;
		level_cfg = '0;
		sustain_cfg = '0;
		silence_cfg = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			chan_armed[c] = 1'b0;
			chan_total[c] = '0;
		end
		send_idle_pct = 31;
		recv_idle_pct = 67;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_random_traffic(650);
		send_idle_pct = 67;
		recv_idle_pct = 31;
		test_random_traffic(650);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(650);
		test_long_accumulation();

		wait_for_quiet();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
